FILE: rtl/rldd_pkg.sv
package rldd_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int LEVEL_W   = 16;
    localparam int VALUE_W   = 32;
    localparam int SQ_W      = 2 * LEVEL_W;
    localparam int COLOR_W   = 3;
    localparam int TABLE_W   = 48;
    localparam int TSIZE_W   = 5;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_LANES = 3;

    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SET_BITS  = 2'd1;
    localparam logic [1:0] CMD_SET_VALUE = 2'd2;
    localparam logic [1:0] CMD_SET_FLOAT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COLORS = 8'd1;

    // Squares at or below this are treated as dark (0.003 in Q0.32).
    localparam logic [SQ_W-1:0] SQ_MIN_KEEP = 32'd12884901;

    localparam int MOD_DIG   = 4;
    localparam int MOD_STEPS = VALUE_W / MOD_DIG;

    typedef struct packed {
        logic pin;
        logic done;
    } lane_status_t;

endpackage

FILE: rtl/rldd_lane.sv
module rldd_lane #(
    parameter int FRAC_BITS = rldd_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rldd_pkg::LEVEL_W-1:0]  level,
    input  logic                          tick,
    output rldd_pkg::lane_status_t        status
);

    localparam int SQ_W  = rldd_pkg::SQ_W;
    localparam int INC_W = FRAC_BITS + 1;
    localparam int ACC_W = FRAC_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
    localparam logic [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_BITS;
    localparam logic [SQ_W:0] SQ_FULL = (SQ_W+1)'(1) << SQ_W;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PREP = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic             main_reg, main_next;
    logic [INC_W-1:0] inc_reg, inc_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [SQ_W+1:0]  rem_reg, rem_next;
    logic [SQ_W:0]    den_reg, den_next;
    logic [INC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic             acc_ge;
    logic [SQ_W-1:0]  sq_kept;
    logic             ge;
    logic [SQ_W+1:0]  rem_sub;

    assign acc_ge = |acc_reg[ACC_W-1:FRAC_BITS];
    assign sq_kept = (sq_reg <= rldd_pkg::SQ_MIN_KEEP) ? '0 : sq_reg;
    assign ge = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    assign status.pin  = acc_ge ? ~main_reg : main_reg;
    assign status.done = done_reg;

    always_comb begin
        phase_next = phase_reg;
        sq_next    = sq_reg;
        main_next  = main_reg;
        inc_next   = inc_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (tick) begin
            acc_next = acc_ge ? (acc_reg - ONE_FX) : (acc_reg + ACC_W'(inc_reg));
        end
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    sq_next    = {16'b0, level} * {16'b0, level};
                    phase_next = PH_PREP;
                end
            end
            PH_PREP: begin
                main_next = sq_reg[SQ_W-1];
                if (sq_reg[SQ_W-1]) begin
                    rem_next = (SQ_W+2)'(SQ_FULL - {1'b0, sq_reg});
                    den_next = {1'b0, sq_reg};
                end else begin
                    rem_next = (SQ_W+2)'(sq_kept);
                    den_next = SQ_FULL - {1'b0, sq_kept};
                end
                quo_next   = '0;
                cnt_next   = '0;
                phase_next = PH_DIV;
            end
            PH_DIV: begin
                rem_next = {rem_sub[SQ_W:0], 1'b0};
                quo_next = {quo_reg[INC_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    inc_next   = {quo_reg[INC_W-2:0], ge};
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            main_reg  <= 1'b0;
            inc_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            main_reg  <= main_next;
            inc_reg   <= inc_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: rtl/rldd_mod.sv
module rldd_mod #(
    parameter int TABLE_ENTRIES = rldd_pkg::TABLE_ENTRIES_DEF,
    localparam int RW = $clog2(TABLE_ENTRIES) + 1,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rldd_pkg::VALUE_W-1:0]  value,
    input  logic [RW-1:0]                 modulus,
    output logic                          done,
    output logic [IW-1:0]                 index
);

    localparam int VW    = rldd_pkg::VALUE_W;
    localparam int DIG   = rldd_pkg::MOD_DIG;
    localparam int CNT_W = $clog2(rldd_pkg::MOD_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rldd_pkg::MOD_STEPS - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]    sh_reg, sh_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [RW-1:0]    mod_reg, mod_next;
    logic             done_reg, done_next;
    logic [IW-1:0]    idx_reg, idx_next;

    logic [RW-1:0]    rem_step;
    logic [RW:0]      trial;
    logic [RW-1:0]    rem_fin;

    assign done  = done_reg;
    assign index = idx_reg;

    // Restoring remainder over the magnitude, several bits per cycle.
    always_comb begin
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < DIG; k++) begin
            trial = {rem_step, sh_reg[VW-1-k]};
            if (trial >= {1'b0, mod_reg}) begin
                trial = trial - {1'b0, mod_reg};
            end
            rem_step = trial[RW-1:0];
        end
    end

    assign rem_fin = (neg_reg && (rem_step != '0)) ? (mod_reg - rem_step) : rem_step;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        mod_next  = mod_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        if (busy_reg) begin
            sh_next  = sh_reg << DIG;
            rem_next = rem_step;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                idx_next  = IW'(rem_fin);
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = value[VW-1];
            sh_next   = value[VW-1] ? (~value + VW'(1)) : value;
            rem_next  = '0;
            mod_next  = modulus;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        mod_reg <= mod_next;
        idx_reg <= idx_next;
    end

endmodule

FILE: rtl/rgb_led_dither_dimmer_unit.sv
// RGB LED dimmer with error-accumulator dithering. Ticks, set_bits and set_value
// without a color table place their pin beat straight in the result slots;
// set_value with a table keeps the input closed while the modulo unit works
// four bits of the value per cycle; set_float keeps it closed while the
// three channel lanes each square their level, set up the divider in the
// next cycle and then find the increment with a restoring divider producing
// one quotient bit per cycle. A tick arriving before the first set_float
// gives no beat. A result waiting on the output does not stall the input,
// as a second result slot holds one more beat; the input closes while that
// second slot is full.
module rgb_led_dither_dimmer_unit #(
    parameter int TABLE_ENTRIES = rldd_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = rldd_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: value, red_level, green_level, blue_level.
    input  logic [79:0]                     s_tdata,
    // Fields from bit 0: cmd.
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: red_on, green_on, blue_on, then zero fill.
    output logic [7:0]                      m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rldd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rldd_pkg::TABLE_W-1:0]    cfg_data
);

    localparam int RW = $clog2(TABLE_ENTRIES) + 1;
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = rldd_pkg::COLOR_W;
    localparam int LW = rldd_pkg::LEVEL_W;
    localparam int VW = rldd_pkg::VALUE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOD   = 2'd1;
    localparam logic [1:0] ST_FLOAT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic                            float_reg, float_next;
    logic [rldd_pkg::TSIZE_W-1:0]    tsize_reg;
    logic [rldd_pkg::TABLE_W-1:0]    colors_reg;
    logic                            out_v_reg, out_v_next;
    logic [CW-1:0]                   out_d_reg, out_d_next;
    logic                            pend_v_reg, pend_v_next;
    logic [CW-1:0]                   pend_d_reg, pend_d_next;

    logic                            accept;
    logic [1:0]                      cmd;
    logic [VW-1:0]                   value;
    logic                            res_v;
    logic [CW-1:0]                   res_d;
    logic [RW-1:0]                   modulus;
    logic                            mod_start;
    logic                            mod_done;
    logic [IW-1:0]                   mod_idx;
    logic [5:0]                      idx6;
    logic [5:0]                      col_base;
    logic                            lane_start;
    logic                            lane_tick;
    rldd_pkg::lane_status_t          lane_st [rldd_pkg::NUM_LANES];
    logic [rldd_pkg::NUM_LANES-1:0]  lane_pins;
    logic [rldd_pkg::NUM_LANES-1:0]  lane_done;

    assign cmd      = s_tuser;
    assign value    = s_tdata[VW-1:0];
    assign s_tready = (state_reg == ST_IDLE) && !pend_v_reg;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign modulus = (tsize_reg > rldd_pkg::TSIZE_W'(TABLE_ENTRIES))
                   ? RW'(TABLE_ENTRIES) : RW'(tsize_reg);
    assign mod_start  = accept && (cmd == rldd_pkg::CMD_SET_VALUE) && (tsize_reg != '0);
    assign lane_start = accept && (cmd == rldd_pkg::CMD_SET_FLOAT);
    assign lane_tick  = accept && (cmd == rldd_pkg::CMD_TICK) && float_reg;

    rldd_mod #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (value),
        .modulus (modulus),
        .done    (mod_done),
        .index   (mod_idx)
    );

    for (genvar g = 0; g < rldd_pkg::NUM_LANES; g++) begin : g_lane
        rldd_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .level   (s_tdata[VW + LW*g +: LW]),
            .tick    (lane_tick),
            .status  (lane_st[g])
        );
        assign lane_pins[g] = lane_st[g].pin;
        assign lane_done[g] = lane_st[g].done;
    end

    assign idx6     = 6'(mod_idx);
    assign col_base = (idx6 << 1) + idx6;

    // Merge the lanes, the direct bits and the table lookup into one beat.
    always_comb begin
        res_v = 1'b0;
        res_d = value[CW-1:0];
        if (mod_done) begin
            res_v = 1'b1;
            res_d = colors_reg[col_base +: CW];
        end else if (accept) begin
            case (cmd)
                rldd_pkg::CMD_TICK: begin
                    res_v = float_reg;
                    res_d = lane_pins;
                end
                rldd_pkg::CMD_SET_BITS: begin
                    res_v = 1'b1;
                end
                rldd_pkg::CMD_SET_VALUE: begin
                    res_v = (tsize_reg == '0);
                end
                default: begin
                    res_v = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        float_next = float_reg;
        case (state_reg)
            ST_IDLE: begin
                if (mod_start) begin
                    state_next = ST_MOD;
                end else if (lane_start) begin
                    state_next = ST_FLOAT;
                    float_next = 1'b1;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLOAT: begin
                if (&lane_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        pend_v_next = pend_v_reg;
        pend_d_next = pend_d_reg;
        if (out_v_reg && m_tready) begin
            out_v_next  = pend_v_reg;
            out_d_next  = pend_d_reg;
            pend_v_next = 1'b0;
        end
        if (res_v) begin
            if (!out_v_next) begin
                out_v_next = 1'b1;
                out_d_next = res_d;
            end else begin
                pend_v_next = 1'b1;
                pend_d_next = res_d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            float_reg  <= 1'b0;
            tsize_reg  <= '0;
            colors_reg <= '0;
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            float_reg  <= float_next;
            out_v_reg  <= out_v_next;
            pend_v_reg <= pend_v_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rldd_pkg::REG_TABLE_SIZE: begin
                        tsize_reg <= cfg_data[rldd_pkg::TSIZE_W-1:0];
                    end
                    rldd_pkg::REG_TABLE_COLORS: begin
                        colors_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg  <= out_d_next;
        pend_d_reg <= pend_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'b0, out_d_reg};

endmodule

FILE: rtl/rldd_checker.sv
module rldd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [79:0]                     s_tdata,
    input logic [1:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [7:0]                      m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    logic in_beat;

    assign in_beat = s_tvalid && s_tready;

    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // The pad bits above the three pins stay zero.
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'b0))
        else $error("output pad bits set");

    // A set_float beat keeps the input closed while the lanes divide.
    a_float_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && (s_tuser == rldd_pkg::CMD_SET_FLOAT) |=> !s_tready)
        else $error("input open during set_float");

    // With the output free, set_bits shows its pins on the next cycle.
    a_bits_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && (s_tuser == rldd_pkg::CMD_SET_BITS) && (!m_tvalid || m_tready)
        |=> m_tvalid && (m_tdata[2:0] == $past(s_tdata[2:0])))
        else $error("set_bits beat missing or wrong");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgb_led_dither_dimmer_unit rldd_checker u_rldd_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import rldd_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd9;

    localparam logic [63:0] SQ_ONE = 64'h1_0000_0000;
    localparam logic [FRAC_BITS_DEF+1:0] PHASE_ONE = (FRAC_BITS_DEF+2)'(1) << FRAC_BITS_DEF;

    // Levels on either side of the half-power point and of the dark cutoff.
    localparam logic [LEVEL_W-1:0] HALF_LEVEL = 16'd46340;
    localparam logic [LEVEL_W-1:0] DARK_LEVEL = 16'd3589;

    typedef struct packed {
        logic [LEVEL_W-1:0]        blue;
        logic [LEVEL_W-1:0]        green;
        logic [LEVEL_W-1:0]        red;
        logic signed [VALUE_W-1:0] value;
    } dimmer_word_t;

    typedef struct packed {
        logic blue;
        logic green;
        logic red;
    } pin_set_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [79:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TABLE_W-1:0]   cfg_data  = '0;

    bit                     dither_on = 1'b0;
    bit                     lane_polarity [NUM_LANES] = '{default: 1'b0};
    logic [FRAC_BITS_DEF:0] lane_step [NUM_LANES] = '{default: '0};
    logic [FRAC_BITS_DEF+1:0] lane_phase [NUM_LANES] = '{default: '0};
    logic [TSIZE_W-1:0]     table_len = '0;
    logic [TABLE_W-1:0]     table_bits = '0;
    pin_set_t               expected_pins [$];

    pin_set_t got_pins;
    pin_set_t want_pins;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;
    bit hold_active  = 1'b0;

    int mismatches      = 0;
    int items_sent      = 0;
    int beats_checked   = 0;
    int dither_beats    = 0;
    int level_loads     = 0;
    int regs_written    = 0;
    int quiet_cycles    = 0;

    rgb_led_dither_dimmer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic void load_lane(input int lane, input logic [LEVEL_W-1:0] level);
        logic [63:0] sq;
        logic [63:0] quot;
        sq = 64'(level) * 64'(level);
        if (sq >= (SQ_ONE >> 1)) begin
            lane_polarity[lane] = 1'b1;
            quot = ((SQ_ONE - sq) << FRAC_BITS_DEF) / sq;
        end else begin
            if (sq <= 64'(SQ_MIN_KEEP)) begin
                sq = '0;
            end
            lane_polarity[lane] = 1'b0;
            quot = (sq << FRAC_BITS_DEF) / (SQ_ONE - sq);
        end
        lane_step[lane] = quot[FRAC_BITS_DEF:0];
    endfunction

    // The remainder is taken on the signed value and folded to be non-negative.
    function automatic pin_set_t table_color(input logic signed [VALUE_W-1:0] value);
        int                 entries;
        longint             rem;
        logic [3:0]         slot;
        logic [TABLE_W-1:0] shifted;
        entries = (table_len > TSIZE_W'(TABLE_ENTRIES_DEF)) ? TABLE_ENTRIES_DEF
                                                             : int'(table_len);
        rem = longint'(value) % longint'(entries);
        if (rem < 0) begin
            rem += longint'(entries);
        end
        slot = rem[3:0];
        shifted = table_bits >> (3 * slot);
        return shifted[2:0];
    endfunction

    function automatic void predict_pins(input logic [1:0] cmd, input dimmer_word_t word);
        pin_set_t pins;
        case (cmd)
            CMD_TICK: begin
                if (dither_on) begin
                    for (int lane = 0; lane < NUM_LANES; lane++) begin
                        if (lane_phase[lane] >= PHASE_ONE) begin
                            pins[lane] = ~lane_polarity[lane];
                            lane_phase[lane] -= PHASE_ONE;
                        end else begin
                            pins[lane] = lane_polarity[lane];
                            lane_phase[lane] += (FRAC_BITS_DEF+2)'(lane_step[lane]);
                        end
                    end
                    expected_pins.push_back(pins);
                    dither_beats++;
                end
            end
            CMD_SET_BITS: begin
                expected_pins.push_back(word.value[2:0]);
            end
            CMD_SET_VALUE: begin
                if (table_len == '0) begin
                    pins = word.value[2:0];
                end else begin
                    pins = table_color(word.value);
                end
                expected_pins.push_back(pins);
            end
            CMD_SET_FLOAT: begin
                load_lane(0, word.red);
                load_lane(1, word.green);
                load_lane(2, word.blue);
                dither_on = 1'b1;
                level_loads++;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_TABLE_SIZE) begin
                table_len = cfg_data[TSIZE_W-1:0];
            end else if (cfg_index == REG_TABLE_COLORS) begin
                table_bits = cfg_data;
            end
            regs_written++;
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_pins(s_tuser, s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_pins = m_tdata[2:0];
            beats_checked++;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("pin beat %0d arrived with nothing expected: r%b g%b b%b",
                             beats_checked, got_pins.red, got_pins.green, got_pins.blue);
                end
            end else begin
                want_pins = expected_pins.pop_front();
                if (got_pins !== want_pins) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("pin beat %0d: expected r%b g%b b%b, got r%b g%b b%b",
                                 beats_checked, want_pins.red, want_pins.green,
                                 want_pins.blue, got_pins.red, got_pins.green, got_pins.blue);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
                hold_request = 1'b0;
            end else if (rx_idle_on) begin
                m_tready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic dimmer_word_t make_word(input logic [VALUE_W-1:0] value,
                                               input logic [LEVEL_W-1:0] red,
                                               input logic [LEVEL_W-1:0] green,
                                               input logic [LEVEL_W-1:0] blue);
        dimmer_word_t word;
        word.value = value;
        word.red   = red;
        word.green = green;
        word.blue  = blue;
        return word;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] pick;
        case ($urandom_range(0, 7))
            0: pick = 32'h8000_0000 + 32'($urandom_range(0, 20));
            1: pick = 32'h7FFF_FFFF - 32'($urandom_range(0, 20));
            2: pick = 32'($urandom_range(0, 80)) - 32'd40;
            default: pick = $urandom;
        endcase
        return pick;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        logic [LEVEL_W-1:0] pick;
        case ($urandom_range(0, 9))
            0: pick = '0;
            1: pick = '1;
            2: pick = HALF_LEVEL + 16'($urandom_range(0, 1));
            3: pick = DARK_LEVEL + 16'($urandom_range(0, 1));
            4: pick = 16'($urandom_range(0, 4000));
            5: pick = 16'($urandom_range(60000, 65535));
            default: pick = 16'($urandom_range(0, 65535));
        endcase
        return pick;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input dimmer_word_t word);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [TABLE_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_items(input int count, input bit with_loads);
        logic [1:0] cmd;
        int         roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, with_loads ? 99 : 84);
            if (roll < 45) begin
                cmd = CMD_TICK;
            end else if (roll < 60) begin
                cmd = CMD_SET_BITS;
            end else if (roll < 85) begin
                cmd = CMD_SET_VALUE;
            end else begin
                cmd = CMD_SET_FLOAT;
            end
            send_item(cmd, make_word(pick_value(), pick_level(), pick_level(), pick_level()));
        end
    endtask

    // Ticks before any level load must stay silent, while set_bits beats still come through.
    task automatic test_pins_before_dimming();
        send_item(CMD_TICK, make_word('0, '1, '1, '1));
        send_item(CMD_TICK, make_word('1, '0, '0, '0));
        send_item(CMD_SET_BITS, make_word(32'h0000_0000, '0, '0, '0));
        send_item(CMD_SET_BITS, make_word(32'h0000_0007, '0, '0, '0));
        send_item(CMD_SET_BITS, make_word(32'hFFFF_FFFF, '0, '0, '0));
        send_item(CMD_SET_BITS, make_word(32'h8000_0000, '0, '0, '0));
    endtask

    task automatic test_color_lookup();
        write_reg(REG_TABLE_SIZE, 48'd0);
        send_item(CMD_SET_VALUE, make_word(32'hFFFF_FFFF, '0, '0, '0));
        send_item(CMD_SET_VALUE, make_word(32'h0000_0006, '0, '0, '0));
        write_reg(REG_TABLE_SIZE, 48'd5);
        write_reg(REG_TABLE_COLORS, 48'h9C4E_A531_7B2D);
        write_reg(REG_SPARE, '1);
        send_item(CMD_SET_VALUE, make_word(32'h7FFF_FFFF, '0, '0, '0));
        send_item(CMD_SET_VALUE, make_word(32'h8000_0000, '0, '0, '0));
        send_item(CMD_SET_VALUE, make_word(32'hFFFF_FFFB, '0, '0, '0));
        send_item(CMD_SET_VALUE, make_word(32'h0000_0004, '0, '0, '0));
        write_reg(REG_TABLE_SIZE, 48'd20);
        send_item(CMD_SET_VALUE, make_word(32'hFFFF_FFEF, '0, '0, '0));
    endtask

    task automatic test_dither_levels();
        send_item(CMD_SET_FLOAT, make_word('0, 16'd0, 16'hFFFF, HALF_LEVEL + 16'd1));
        repeat (3) send_item(CMD_TICK, make_word('0, '0, '0, '0));
        send_item(CMD_SET_FLOAT, make_word('0, HALF_LEVEL, DARK_LEVEL, DARK_LEVEL + 16'd1));
        repeat (2) send_item(CMD_TICK, make_word('0, '0, '0, '0));
        send_item(CMD_SET_BITS, make_word(32'h0000_0005, '0, '0, '0));
        send_item(CMD_TICK, make_word('0, '0, '0, '0));
    endtask

    task automatic test_random_settings();
        logic [TSIZE_W-1:0] sizes [8];
        logic [TABLE_W-1:0] colors;
        sizes = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2, 5'd15, 5'd7};
        sizes[5] = 5'($urandom_range(2, 15));
        sizes[6] = 5'($urandom_range(2, 15));
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: colors = '1;
                1: colors = '0;
                default: colors = {16'($urandom), $urandom};
            endcase
            write_reg(REG_TABLE_SIZE, 48'(sizes[phase]));
            write_reg(REG_TABLE_COLORS, colors);
            send_random_items(135, 1'b1);
        end
    endtask

    // The receiver holds off long enough for both result slots to fill.
    task automatic test_output_backpressure();
        s_tvalid <= 1'b0;
        hold_request = 1'b1;
        @(posedge aclk);
        while (!hold_active) @(posedge aclk);
        send_random_items(24, 1'b0);
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        send_random_items(30, 1'b1);
        wait_drained();
        send_random_items(30, 1'b1);
    endtask

    task automatic test_steady_stream();
        write_reg(REG_TABLE_SIZE, 48'($urandom_range(1, 16)));
        write_reg(REG_TABLE_COLORS, {16'($urandom), $urandom});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_items(150, 1'b1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_pins_before_dimming();
        test_color_lookup();
        test_dither_levels();
        test_random_settings();
        test_output_backpressure();
        test_pause_until_drained();
        test_steady_stream();
        wait_drained();
        $display("Sent %0d commands (%0d loads), %0d register writes, %0d beats (%0d ticks).",
                 items_sent, level_loads, regs_written, beats_checked, dither_beats);
        $display("Covered table sizes 0 to 31, threshold levels and a long output stall.");
        if (mismatches == 0 && expected_pins.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
